[rtl/pdb_pkg.sv]
`timescale 1ns / 1ps

package pdb_pkg;

    // Image and frame geometry.
    localparam int IMG_W      = 640;
    localparam int IMG_H      = 480;
    localparam int NPIX       = IMG_W * IMG_H;
    localparam int ADDR_W     = $clog2(NPIX);
    localparam int COL_W      = $clog2(IMG_W);
    localparam int ROW_W      = $clog2(IMG_H);
    localparam int MAX_POINTS = 131072;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths of the command and response beats.
    localparam int CMD_W    = 2;
    localparam int COORD_W  = 20;
    localparam int PIX_Q_W  = 16;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 24;
    localparam int INDEX_W  = 17;

    // One pixel store word: depth above winner index.
    localparam int WORD_W = DEPTH_W + INDEX_W;

    // Configuration port.
    localparam int ROT_W      = 18;
    localparam int OFFSET_W   = 21;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 2;
    localparam logic signed [ROT_W-1:0] ROT_ZZ_RESET = 18'sd65536;

    // Depth arithmetic: Q.16 accumulator wide enough for three products and the offset.
    localparam int PROD_W  = ROT_W + COORD_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int DFULL_W = ACC_W - 16;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2
    } pdb_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED    = 3'd0,
        ST_WON        = 3'd1,
        ST_OFF_IMAGE  = 3'd2,
        ST_BEHIND     = 3'd3,
        ST_OCCLUDED   = 3'd4,
        ST_READ_HIT   = 3'd5,
        ST_READ_EMPTY = 3'd6,
        ST_OVERFLOW   = 3'd7
    } pdb_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ZX       = 2'd0,
        CFG_ROT_ZY       = 2'd1,
        CFG_ROT_ZZ       = 2'd2,
        CFG_DEPTH_OFFSET = 2'd3
    } pdb_cfg_idx_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ROUND,
        S_ADDR,
        S_SUM,
        S_DEPTH,
        S_DECIDE,
        S_SWEEP,
        S_CLR_DONE
    } pdb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic sweep_step;
        logic finish;
        logic finish_clear;
    } pdb_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
    } pdb_stat_t;

endpackage

[rtl/pdb_cmd_if.sv]
`timescale 1ns / 1ps

interface pdb_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic        [pdb_pkg::CMD_W-1:0]     command;
    logic signed [pdb_pkg::COORD_W-1:0]   point_x;
    logic signed [pdb_pkg::COORD_W-1:0]   point_y;
    logic signed [pdb_pkg::COORD_W-1:0]   point_z;
    logic signed [pdb_pkg::PIX_Q_W-1:0]   pixel_u_q;
    logic signed [pdb_pkg::PIX_Q_W-1:0]   pixel_v_q;

    modport source (
        output valid, command, point_x, point_y, point_z, pixel_u_q, pixel_v_q,
        input  ready
    );

    modport sink (
        input  valid, command, point_x, point_y, point_z, pixel_u_q, pixel_v_q,
        output ready
    );
endinterface

[rtl/pdb_rsp_if.sv]
`timescale 1ns / 1ps

interface pdb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pdb_pkg::STATUS_W-1:0]     status;
    logic [pdb_pkg::DEPTH_W-1:0]      depth_mm;
    logic [pdb_pkg::INDEX_W-1:0]      point_index;

    modport source (
        output valid, status, depth_mm, point_index,
        input  ready
    );

    modport sink (
        input  valid, status, depth_mm, point_index,
        output ready
    );
endinterface

[rtl/pdb_ctrl.sv]
`timescale 1ns / 1ps

module pdb_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic [pdb_pkg::CMD_W-1:0]   cmd_command,
    output logic                        cmd_ready,
    input  logic                        rsp_ready,
    output logic                        rsp_valid,
    input  pdb_pkg::pdb_stat_t          stat,
    output pdb_pkg::pdb_ctrl_t          ctrl
);

    pdb_pkg::pdb_state_t state_reg;
    pdb_pkg::pdb_state_t state_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                slot_free;

    // The response register can take a new beat when empty or being drained.
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdb_pkg::S_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = pdb_pkg::S_IDLE;
                end
            end
            pdb_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_command)
                        pdb_pkg::CMD_CLEAR:  state_next = pdb_pkg::S_SWEEP;
                        pdb_pkg::CMD_INSERT: state_next = pdb_pkg::S_ROUND;
                        pdb_pkg::CMD_READ:   state_next = pdb_pkg::S_ROUND;
                        default:             state_next = pdb_pkg::S_IDLE;
                    endcase
                end
            end
            pdb_pkg::S_ROUND:  state_next = pdb_pkg::S_ADDR;
            pdb_pkg::S_ADDR:   state_next = pdb_pkg::S_SUM;
            pdb_pkg::S_SUM:    state_next = pdb_pkg::S_DEPTH;
            pdb_pkg::S_DEPTH:  state_next = pdb_pkg::S_DECIDE;
            pdb_pkg::S_DECIDE:
            begin
                if (slot_free)
                begin
                    state_next = pdb_pkg::S_IDLE;
                end
            end
            pdb_pkg::S_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = pdb_pkg::S_CLR_DONE;
                end
            end
            pdb_pkg::S_CLR_DONE:
            begin
                if (slot_free)
                begin
                    state_next = pdb_pkg::S_IDLE;
                end
            end
            default: state_next = pdb_pkg::S_IDLE;
        endcase
    end

    // Output logic: datapath commands and the command-side ready.
    always_comb
    begin
        ctrl      = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            pdb_pkg::S_IDLE:
            begin
                cmd_ready    = 1'b1;
                ctrl.capture = cmd_valid;
            end
            pdb_pkg::S_INIT:     ctrl.sweep_step   = 1'b1;
            pdb_pkg::S_SWEEP:    ctrl.sweep_step   = 1'b1;
            pdb_pkg::S_DECIDE:   ctrl.finish       = slot_free;
            pdb_pkg::S_CLR_DONE: ctrl.finish_clear = slot_free;
            default:
            begin
                ctrl      = '0;
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Response valid: set on a new beat, cleared when the beat is taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.finish || ctrl.finish_clear)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdb_pkg::S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/pdb_datapath.sv]
`timescale 1ns / 1ps

module pdb_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pdb_pkg::pdb_ctrl_t                  ctrl,
    output pdb_pkg::pdb_stat_t                  stat,
    input  logic        [pdb_pkg::CMD_W-1:0]    command,
    input  logic signed [pdb_pkg::COORD_W-1:0]  point_x,
    input  logic signed [pdb_pkg::COORD_W-1:0]  point_y,
    input  logic signed [pdb_pkg::COORD_W-1:0]  point_z,
    input  logic signed [pdb_pkg::PIX_Q_W-1:0]  pixel_u_q,
    input  logic signed [pdb_pkg::PIX_Q_W-1:0]  pixel_v_q,
    input  logic                                cfg_we,
    input  logic [pdb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [pdb_pkg::STATUS_W-1:0]        status,
    output logic [pdb_pkg::DEPTH_W-1:0]         depth_mm,
    output logic [pdb_pkg::INDEX_W-1:0]         point_index
);

    // Round a Q.4 coordinate to the nearest integer, halves to even.
    function automatic logic signed [12:0] round_q4(input logic [pdb_pkg::PIX_Q_W-1:0] raw);
        logic [pdb_pkg::PIX_Q_W-1:0] biased;
        logic [12:0]                 fl;
        logic                        inc;
        biased = raw ^ 16'h8000;
        fl = {1'b0, biased[15:4]};
        inc = (biased[3:0] > 4'd8) || ((biased[3:0] == 4'd8) && biased[4]);
        round_q4 = $signed(fl + 13'(inc) - 13'd2048);
    endfunction

    // Configuration registers.
    logic signed [pdb_pkg::ROT_W-1:0]    rot_zx_reg;
    logic signed [pdb_pkg::ROT_W-1:0]    rot_zy_reg;
    logic signed [pdb_pkg::ROT_W-1:0]    rot_zz_reg;
    logic signed [pdb_pkg::OFFSET_W-1:0] depth_offset_reg;

    // Frame control state.
    logic [pdb_pkg::CNT_W-1:0]  point_counter_reg;
    logic [pdb_pkg::ADDR_W-1:0] sweep_addr_reg;

    // Captured command beat.
    logic [pdb_pkg::CMD_W-1:0]          cmd_reg;
    logic signed [pdb_pkg::COORD_W-1:0] x_reg;
    logic signed [pdb_pkg::COORD_W-1:0] y_reg;
    logic signed [pdb_pkg::COORD_W-1:0] z_reg;
    logic [pdb_pkg::PIX_Q_W-1:0]        u_q_reg;
    logic [pdb_pkg::PIX_Q_W-1:0]        v_q_reg;
    logic [pdb_pkg::INDEX_W-1:0]        idx_reg;
    logic                               ovf_reg;

    // Pipeline registers.
    logic signed [pdb_pkg::PROD_W-1:0] p0_reg;
    logic signed [pdb_pkg::PROD_W-1:0] p1_reg;
    logic signed [pdb_pkg::PROD_W-1:0] p2_reg;
    logic [pdb_pkg::COL_W-1:0]         col_reg;
    logic [pdb_pkg::ROW_W-1:0]         row_reg;
    logic                              in_img_reg;
    logic [pdb_pkg::ADDR_W-1:0]        addr_reg;
    logic signed [pdb_pkg::ACC_W-1:0]  s01_reg;
    logic signed [pdb_pkg::ACC_W-1:0]  s23_reg;
    logic signed [pdb_pkg::ACC_W-1:0]  acc_reg;
    logic [pdb_pkg::DEPTH_W-1:0]       depth_reg;
    logic                              behind_reg;

    // Pixel stores and their registered read data.
    logic [pdb_pkg::WORD_W-1:0] data_mem [pdb_pkg::NPIX];
    logic                       valid_mem [pdb_pkg::NPIX];
    logic [pdb_pkg::WORD_W-1:0] rd_word_reg;
    logic                       rd_valid_reg;

    // Combinational intermediates.
    logic signed [pdb_pkg::COORD_W:0]   neg_x;
    logic signed [pdb_pkg::COORD_W:0]   neg_y;
    logic signed [12:0]                 u_rnd;
    logic signed [12:0]                 v_rnd;
    logic                               u_in;
    logic                               v_in;
    logic signed [pdb_pkg::ACC_W-1:0]   off_sh;
    logic signed [pdb_pkg::ACC_W-1:0]   acc_rnd;
    logic [pdb_pkg::DFULL_W-1:0]        d_full;
    logic [pdb_pkg::DEPTH_W-1:0]        depth_sat;
    logic [pdb_pkg::DEPTH_W-1:0]        stored_depth;
    logic                               behind;
    logic                               win;
    logic                               valid_we;
    logic [pdb_pkg::ADDR_W-1:0]         valid_waddr;
    pdb_pkg::pdb_status_t               status_next;
    logic [pdb_pkg::DEPTH_W-1:0]        depth_next;
    logic [pdb_pkg::INDEX_W-1:0]        index_next;

    // Configuration writes; the host must issue them only while no command is in flight; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_zx_reg       <= '0;
            rot_zy_reg       <= '0;
            rot_zz_reg       <= pdb_pkg::ROT_ZZ_RESET;
            depth_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pdb_pkg::CFG_ROT_ZX:       rot_zx_reg <= $signed(cfg_data[pdb_pkg::ROT_W-1:0]);
                pdb_pkg::CFG_ROT_ZY:       rot_zy_reg <= $signed(cfg_data[pdb_pkg::ROT_W-1:0]);
                pdb_pkg::CFG_ROT_ZZ:       rot_zz_reg <= $signed(cfg_data[pdb_pkg::ROT_W-1:0]);
                pdb_pkg::CFG_DEPTH_OFFSET: depth_offset_reg <= $signed(cfg_data);
                default:                   ;
            endcase
        end
    end

    // Point numbering: a clear restarts it, an insert that fits takes the next index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_counter_reg <= '0;
        end
        else if (ctrl.capture)
        begin
            if (command == pdb_pkg::CMD_CLEAR)
            begin
                point_counter_reg <= '0;
            end
            else if ((command == pdb_pkg::CMD_INSERT) &&
                     (point_counter_reg < pdb_pkg::CNT_W'(pdb_pkg::MAX_POINTS)))
            begin
                point_counter_reg <= point_counter_reg + 1'b1;
            end
        end
    end

    // Sweep address for clearing the valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
        end
        else if (ctrl.sweep_step)
        begin
            sweep_addr_reg <= stat.sweep_last ? '0 : sweep_addr_reg + 1'b1;
        end
    end

    assign stat.sweep_last = (sweep_addr_reg == pdb_pkg::ADDR_W'(pdb_pkg::NPIX - 1));

    // Capture of the command beat.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= command;
            x_reg   <= point_x;
            y_reg   <= point_y;
            z_reg   <= point_z;
            u_q_reg <= pixel_u_q;
            v_q_reg <= pixel_v_q;
            idx_reg <= pdb_pkg::INDEX_W'(point_counter_reg);
            ovf_reg <= (point_counter_reg >= pdb_pkg::CNT_W'(pdb_pkg::MAX_POINTS));
        end
    end

    // Stage one: pixel rounding and the three depth products.
    assign neg_x = -{x_reg[pdb_pkg::COORD_W-1], x_reg};
    assign neg_y = -{y_reg[pdb_pkg::COORD_W-1], y_reg};
    assign u_rnd = round_q4(u_q_reg);
    assign v_rnd = round_q4(v_q_reg);
    assign u_in  = !u_rnd[12] && ({1'b0, $unsigned(u_rnd)} < 14'(pdb_pkg::IMG_W));
    assign v_in  = !v_rnd[12] && ({1'b0, $unsigned(v_rnd)} < 14'(pdb_pkg::IMG_H));

    always_ff @(posedge clk)
    begin
        p0_reg     <= rot_zx_reg * neg_x;
        p1_reg     <= rot_zy_reg * neg_y;
        p2_reg     <= rot_zz_reg * z_reg;
        col_reg    <= pdb_pkg::COL_W'($unsigned(u_rnd));
        row_reg    <= pdb_pkg::ROW_W'($unsigned(v_rnd));
        in_img_reg <= u_in && v_in;
    end

    // Stage two: pixel address and the partial sums.
    assign off_sh = pdb_pkg::ACC_W'($signed({depth_offset_reg, 16'h0000}));

    always_ff @(posedge clk)
    begin
        if (in_img_reg)
        begin
            addr_reg <= pdb_pkg::ADDR_W'(row_reg) * pdb_pkg::ADDR_W'(pdb_pkg::IMG_W)
                      + pdb_pkg::ADDR_W'(col_reg);
        end
        else
        begin
            addr_reg <= '0;
        end
        s01_reg <= pdb_pkg::ACC_W'(p0_reg) + pdb_pkg::ACC_W'(p1_reg);
        s23_reg <= pdb_pkg::ACC_W'(p2_reg) + off_sh;
    end

    // Stage three: full accumulator.
    always_ff @(posedge clk)
    begin
        acc_reg <= s01_reg + s23_reg;
    end

    // Stage four: round to whole millimetres and saturate.
    assign acc_rnd   = acc_reg + pdb_pkg::ACC_W'(32768);
    assign d_full    = acc_rnd[pdb_pkg::ACC_W-1:16];
    assign behind    = (acc_reg < $signed(pdb_pkg::ACC_W'(32768)));
    assign depth_sat = (|d_full[pdb_pkg::DFULL_W-1:pdb_pkg::DEPTH_W]) ? pdb_pkg::DEPTH_MAX
                     : d_full[pdb_pkg::DEPTH_W-1:0];

    always_ff @(posedge clk)
    begin
        depth_reg  <= depth_sat;
        behind_reg <= behind;
    end

    // Depth held for the addressed pixel.
    assign stored_depth = rd_word_reg[pdb_pkg::WORD_W-1:pdb_pkg::INDEX_W];

    // Decision: status, response fields and whether the point wins its pixel.
    always_comb
    begin
        status_next = pdb_pkg::ST_READ_EMPTY;
        depth_next  = '0;
        index_next  = '0;
        win         = 1'b0;
        if (ctrl.finish_clear)
        begin
            status_next = pdb_pkg::ST_CLEARED;
        end
        else if (cmd_reg == pdb_pkg::CMD_READ)
        begin
            if (in_img_reg && rd_valid_reg)
            begin
                status_next = pdb_pkg::ST_READ_HIT;
                depth_next  = stored_depth;
                index_next  = rd_word_reg[pdb_pkg::INDEX_W-1:0];
            end
        end
        else if (ovf_reg)
        begin
            status_next = pdb_pkg::ST_OVERFLOW;
        end
        else
        begin
            index_next = idx_reg;
            if (!in_img_reg)
            begin
                status_next = pdb_pkg::ST_OFF_IMAGE;
            end
            else if (behind_reg)
            begin
                status_next = pdb_pkg::ST_BEHIND;
            end
            else
            begin
                depth_next = depth_reg;
                if (!rd_valid_reg || (depth_reg < stored_depth))
                begin
                    status_next = pdb_pkg::ST_WON;
                    win         = 1'b1;
                end
                else
                begin
                    status_next = pdb_pkg::ST_OCCLUDED;
                end
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (ctrl.finish || ctrl.finish_clear)
        begin
            status      <= status_next;
            depth_mm    <= depth_next;
            point_index <= index_next;
        end
    end

    // Depth and winner store.
    always_ff @(posedge clk)
    begin
        rd_word_reg <= data_mem[addr_reg];
        if (ctrl.finish && win)
        begin
            data_mem[addr_reg] <= {depth_reg, idx_reg};
        end
    end

    // Valid-bit store: cleared by the sweep, set by a winning insert.
    assign valid_we    = ctrl.sweep_step || (ctrl.finish && win);
    assign valid_waddr = ctrl.sweep_step ? sweep_addr_reg : addr_reg;

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_mem[addr_reg];
        if (valid_we)
        begin
            valid_mem[valid_waddr] <= !ctrl.sweep_step;
        end
    end

endmodule

[rtl/point_depth_buffer.sv]
// Insert and read: a command beat is accepted only in the idle state, so the next beat waits
// until the rounding, product, sum, depth and decision stages around one store read are done.
// The decision stage loads the response into an output register and waits while it is full.
// Clear: one valid bit per cycle over the whole image, then a cleared response.
// Reset (rst_n low, asynchronous) runs the same sweep, with no response;
// configuration registers return to their reset values at once.
`timescale 1ns / 1ps

module point_depth_buffer (
    input  logic                               clk,
    input  logic                               rst_n,
    pdb_cmd_if.sink                            cmd,
    pdb_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [pdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pdb_pkg::pdb_ctrl_t ctrl;
    pdb_pkg::pdb_stat_t stat;

    // Sequencer.
    pdb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_command (cmd.command),
        .cmd_ready   (cmd.ready),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .stat        (stat),
        .ctrl        (ctrl)
    );

    // Depth arithmetic and pixel stores.
    pdb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .command     (cmd.command),
        .point_x     (cmd.point_x),
        .point_y     (cmd.point_y),
        .point_z     (cmd.point_z),
        .pixel_u_q   (cmd.pixel_u_q),
        .pixel_v_q   (cmd.pixel_v_q),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (rsp.status),
        .depth_mm    (rsp.depth_mm),
        .point_index (rsp.point_index)
    );

    // A new response is loaded only when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.finish || ctrl.finish_clear) |-> (!rsp.valid || rsp.ready))
        else $error("response loaded over a beat still waiting");

    // Every loaded response shows up as a valid beat on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.finish || ctrl.finish_clear) |=> rsp.valid)
        else $error("loaded response not presented");

    // Capture, sweep and completion never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.capture, ctrl.sweep_step, ctrl.finish, ctrl.finish_clear}))
        else $error("conflicting datapath commands");

    // No command is taken while the store is being swept.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.sweep_step |-> !cmd.ready)
        else $error("command accepted during clearing sweep");

endmodule
